// ----- rtl/bvm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared constants, codes and types of the byte-coded machine step block.
// ----------------------------------------------------------------------------
package bvm_pkg;

    localparam int MEM_BYTES = 4096;
    localparam int REG_COUNT = 8;
    localparam int SCREEN_W  = 32;
    localparam int SCREEN_H  = 32;
    localparam int FB_BASE   = 256;

    localparam int MEM_AW = $clog2(MEM_BYTES);
    localparam int PC_W   = MEM_AW + 1;
    localparam int REG_AW = $clog2(REG_COUNT);
    localparam int SEL_W  = 3;
    localparam int BYTE_W = 8;
    localparam int ERR_W  = 3;
    localparam int CMD_W  = 2;
    // wide enough for FB_BASE + 255 * SCREEN_W + 255 at the largest settings
    localparam int PIX_W  = 18;

    // host commands
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

    // instruction opcodes
    localparam logic [BYTE_W-1:0] OPC_LOAD  = 8'd1;
    localparam logic [BYTE_W-1:0] OPC_ADD   = 8'd2;
    localparam logic [BYTE_W-1:0] OPC_SUB   = 8'd3;
    localparam logic [BYTE_W-1:0] OPC_STORE = 8'd4;
    localparam logic [BYTE_W-1:0] OPC_PRINT = 8'd5;
    localparam logic [BYTE_W-1:0] OPC_JZ    = 8'd6;
    localparam logic [BYTE_W-1:0] OPC_JMP   = 8'd7;
    localparam logic [BYTE_W-1:0] OPC_PIX   = 8'd8;
    localparam logic [BYTE_W-1:0] OPC_PIXR  = 8'd9;
    localparam logic [BYTE_W-1:0] OPC_HALT  = 8'hFF;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE = 3'd0;
    localparam logic [ERR_W-1:0] ERR_PC   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_REG  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_ADDR = 3'd3;
    localparam logic [ERR_W-1:0] ERR_OPC  = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_STEP,
        S_F1,
        S_F2,
        S_F3,
        S_F4,
        S_R3,
        S_EXEC,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [PC_W-1:0]   pc_now;
        logic              halted_flag;
        logic [ERR_W-1:0]  error_code;
        logic [BYTE_W-1:0] reg_value;
        logic [BYTE_W-1:0] mem_value;
        logic              print_valid;
        logic [BYTE_W-1:0] print_value;
        logic [BYTE_W-1:0] fetched_byte;
    } t_res;

endpackage
`default_nettype wire

// ----- rtl/bvm_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bvm_if
// Channel interfaces: host command in, result out, configuration write.
// ----------------------------------------------------------------------------
interface bvm_in_if;
    logic                        valid;
    logic                        ready;
    logic [bvm_pkg::CMD_W-1:0]   opcode;
    logic [bvm_pkg::MEM_AW-1:0]  mem_addr;
    logic [bvm_pkg::BYTE_W-1:0]  mem_data;
    logic [bvm_pkg::SEL_W-1:0]   reg_select;

    modport source (output valid, opcode, mem_addr, mem_data, reg_select, input ready);
    modport sink   (input valid, opcode, mem_addr, mem_data, reg_select, output ready);
endinterface

interface bvm_out_if;
    logic                        valid;
    logic                        ready;
    logic [bvm_pkg::PC_W-1:0]    pc_now;
    logic                        halted_flag;
    logic [bvm_pkg::ERR_W-1:0]   error_code;
    logic [bvm_pkg::BYTE_W-1:0]  reg_value;
    logic [bvm_pkg::BYTE_W-1:0]  mem_value;
    logic                        print_valid;
    logic [bvm_pkg::BYTE_W-1:0]  print_value;
    logic [bvm_pkg::BYTE_W-1:0]  fetched_byte;

    modport source (output valid, pc_now, halted_flag, error_code, reg_value, mem_value,
                    print_valid, print_value, fetched_byte, input ready);
    modport sink   (input valid, pc_now, halted_flag, error_code, reg_value, mem_value,
                    print_valid, print_value, fetched_byte, output ready);
endinterface

interface bvm_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bvm_pkg::PC_W-1:0]    program_length;

    modport source (output valid, program_length, input ready);
    modport sink   (input valid, program_length, output ready);
endinterface
`default_nettype wire

// ----- rtl/byte_vm_instruction_step.sv -----
`default_nettype none
// From command transfer to result in the output register: write runs S_WRITE, S_FIN, S_DONE;
// query / machine reset S_FIN, S_DONE; step S_STEP, S_F1-S_F4, S_R3, S_EXEC, S_FIN, S_DONE
// (S_STEP, S_FIN, S_DONE when halted or pc is out of window). A new command is taken only in
// S_IDLE; the single-port byte memory is read one byte per cycle (four fetch reads), then the
// register RAM for up to three operands. Reset: a clearing pass zeroes all MEM_BYTES (4096)
// bytes with the command channel not ready; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// byte_vm_instruction_step
// Byte-coded machine: host commands write memory, reset, query or step one
// instruction. State kept in a byte RAM and a register RAM.
// ----------------------------------------------------------------------------
module byte_vm_instruction_step (
    input  wire       i_clk,
    input  wire       i_rst_n,
    bvm_in_if.sink    i_cmd,
    bvm_out_if.source o_res,
    bvm_cfg_if.sink   i_cfg
);

    localparam int MAW = bvm_pkg::MEM_AW;
    localparam int PW  = bvm_pkg::PC_W;
    localparam int RAW = bvm_pkg::REG_AW;
    localparam int BW  = bvm_pkg::BYTE_W;
    localparam int EW  = bvm_pkg::ERR_W;
    localparam int XW  = bvm_pkg::PIX_W;

    // storage
    logic [BW-1:0] mem [bvm_pkg::MEM_BYTES];
    logic [BW-1:0] regs [bvm_pkg::REG_COUNT];

    // memory ports
    logic           mem_we, mem_re, mem_oob;
    logic [PW-1:0]  mem_fa;
    logic [BW-1:0]  mem_wd;
    logic [BW-1:0]  r_mem_q;
    logic           r_mem_qz;
    logic [BW-1:0]  mem_rdata;
    logic           reg_we, reg_re;
    logic [RAW-1:0] reg_a;
    logic [BW-1:0]  reg_wd;
    logic [BW-1:0]  r_reg_q;
    logic           r_reg_qv;
    logic [BW-1:0]  reg_rdata;

    // control and payload registers
    bvm_pkg::t_state r_state, n_state;
    logic [MAW-1:0]  r_clr_cnt, n_clr_cnt;
    logic [PW-1:0]   r_plen, n_plen;
    logic [PW-1:0]   r_pc, n_pc;
    logic            r_stopped, n_stopped;
    logic [EW-1:0]   r_fault, n_fault;
    logic [bvm_pkg::REG_COUNT-1:0] r_reg_vld, n_reg_vld;
    logic [MAW-1:0]  r_addr, n_addr;
    logic [BW-1:0]   r_data, n_data;
    logic [bvm_pkg::SEL_W-1:0] r_sel, n_sel;
    logic [BW-1:0]   r_op, n_op;
    logic [BW-1:0]   r_b1, n_b1;
    logic [BW-1:0]   r_b2, n_b2;
    logic [BW-1:0]   r_b3, n_b3;
    logic [BW-1:0]   r_ra, n_ra;
    logic [BW-1:0]   r_rb, n_rb;
    logic [BW-1:0]   r_fetched, n_fetched;
    logic            r_pv, n_pv;
    logic [BW-1:0]   r_pval, n_pval;
    logic            r_out_valid, n_out_valid;
    bvm_pkg::t_res   r_out, n_out;

    logic cmd_xfer;

    assign cmd_xfer    = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == bvm_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign mem_oob   = (mem_fa >= PW'(bvm_pkg::MEM_BYTES));
    assign mem_rdata = r_mem_qz ? '0 : r_mem_q;
    assign reg_rdata = r_reg_qv ? r_reg_q : '0;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        logic [PW:0]    pc_x;
        logic           w2, w3, w4;
        logic           ok1, ok2, ok3;
        logic [BW-1:0]  px, py, pcol;
        logic [XW-1:0]  pix_a;
        logic           pix_in;
        logic [EW-1:0]  err;
        logic [BW-1:0]  rc;

        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_plen      = r_plen;
        n_pc        = r_pc;
        n_stopped   = r_stopped;
        n_fault     = r_fault;
        n_reg_vld   = r_reg_vld;
        n_addr      = r_addr;
        n_data      = r_data;
        n_sel       = r_sel;
        n_op        = r_op;
        n_b1        = r_b1;
        n_b2        = r_b2;
        n_b3        = r_b3;
        n_ra        = r_ra;
        n_rb        = r_rb;
        n_fetched   = r_fetched;
        n_pv        = r_pv;
        n_pval      = r_pval;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;

        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_fa = PW'(r_addr);
        mem_wd = '0;
        reg_we = 1'b0;
        reg_re = 1'b0;
        reg_a  = r_sel[RAW-1:0];
        reg_wd = '0;

        pc_x   = {1'b0, r_pc};
        w2     = (pc_x + (PW+1)'(2)) > {1'b0, r_plen};
        w3     = (pc_x + (PW+1)'(3)) > {1'b0, r_plen};
        w4     = (pc_x + (PW+1)'(4)) > {1'b0, r_plen};
        ok1    = 32'(r_b1) < bvm_pkg::REG_COUNT;
        ok2    = 32'(r_b2) < bvm_pkg::REG_COUNT;
        ok3    = 32'(r_b3) < bvm_pkg::REG_COUNT;
        rc     = reg_rdata;
        err    = bvm_pkg::ERR_NONE;
        // PIX takes its operands from the instruction bytes, PIXR from registers
        px     = (r_op == bvm_pkg::OPC_PIXR) ? r_ra : r_b1;
        py     = (r_op == bvm_pkg::OPC_PIXR) ? r_rb : r_b2;
        pcol   = (r_op == bvm_pkg::OPC_PIXR) ? rc   : r_b3;
        pix_in = (32'(px) < bvm_pkg::SCREEN_W) && (32'(py) < bvm_pkg::SCREEN_H);
        pix_a  = XW'(bvm_pkg::FB_BASE) + XW'(py) * XW'(bvm_pkg::SCREEN_W) + XW'(px);

        if (i_cfg.valid) begin
            if (i_cfg.program_length > PW'(bvm_pkg::MEM_BYTES)) begin
                n_plen = PW'(bvm_pkg::MEM_BYTES);
            end else begin
                n_plen = i_cfg.program_length;
            end
        end

        case (r_state)
            bvm_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_fa    = PW'(r_clr_cnt);
                n_clr_cnt = r_clr_cnt + MAW'(1);
                if (r_clr_cnt == MAW'(bvm_pkg::MEM_BYTES - 1)) begin
                    n_state = bvm_pkg::S_IDLE;
                end
            end
            bvm_pkg::S_IDLE: begin
                if (cmd_xfer) begin
                    n_addr    = i_cmd.mem_addr;
                    n_data    = i_cmd.mem_data;
                    n_sel     = i_cmd.reg_select;
                    n_fetched = '0;
                    n_pv      = 1'b0;
                    n_pval    = '0;
                    case (i_cmd.opcode)
                        bvm_pkg::CMD_WRITE: n_state = bvm_pkg::S_WRITE;
                        bvm_pkg::CMD_STEP:  n_state = bvm_pkg::S_STEP;
                        bvm_pkg::CMD_RESET: begin
                            n_reg_vld = '0;
                            n_pc      = '0;
                            n_stopped = 1'b0;
                            n_fault   = bvm_pkg::ERR_NONE;
                            n_state   = bvm_pkg::S_FIN;
                        end
                        default: n_state = bvm_pkg::S_FIN;
                    endcase
                end
            end
            bvm_pkg::S_WRITE: begin
                mem_fa  = PW'(r_addr);
                mem_we  = !mem_oob;
                mem_wd  = r_data;
                n_state = bvm_pkg::S_FIN;
            end
            bvm_pkg::S_STEP: begin
                if (r_stopped) begin
                    n_state = bvm_pkg::S_FIN;
                end else if ((pc_x + (PW+1)'(1)) > {1'b0, r_plen}) begin
                    n_stopped = 1'b1;
                    n_fault   = bvm_pkg::ERR_PC;
                    n_state   = bvm_pkg::S_FIN;
                end else begin
                    mem_re  = 1'b1;
                    mem_fa  = r_pc;
                    n_state = bvm_pkg::S_F1;
                end
            end
            bvm_pkg::S_F1: begin
                n_op      = mem_rdata;
                n_fetched = mem_rdata;
                mem_re    = 1'b1;
                mem_fa    = r_pc + PW'(1);
                n_state   = bvm_pkg::S_F2;
            end
            bvm_pkg::S_F2: begin
                n_b1    = mem_rdata;
                mem_re  = 1'b1;
                mem_fa  = r_pc + PW'(2);
                n_state = bvm_pkg::S_F3;
            end
            bvm_pkg::S_F3: begin
                n_b2    = mem_rdata;
                mem_re  = 1'b1;
                mem_fa  = r_pc + PW'(3);
                reg_re  = 1'b1;
                reg_a   = r_b1[RAW-1:0];
                n_state = bvm_pkg::S_F4;
            end
            bvm_pkg::S_F4: begin
                n_b3    = mem_rdata;
                n_ra    = reg_rdata;
                reg_re  = 1'b1;
                reg_a   = r_b2[RAW-1:0];
                n_state = bvm_pkg::S_R3;
            end
            bvm_pkg::S_R3: begin
                n_rb    = reg_rdata;
                reg_re  = 1'b1;
                reg_a   = r_b3[RAW-1:0];
                n_state = bvm_pkg::S_EXEC;
            end
            bvm_pkg::S_EXEC: begin
                // operand values: ra = reg[b1], rb = reg[b2], rc = reg[b3]
                n_state = bvm_pkg::S_FIN;
                reg_a   = r_b1[RAW-1:0];
                case (r_op)
                    bvm_pkg::OPC_LOAD: begin
                        if (w3)        err = bvm_pkg::ERR_PC;
                        else if (!ok1) err = bvm_pkg::ERR_REG;
                        else begin
                            reg_we = 1'b1;
                            reg_wd = r_b2;
                            n_pc   = r_pc + PW'(3);
                        end
                    end
                    bvm_pkg::OPC_ADD, bvm_pkg::OPC_SUB: begin
                        if (w4)                      err = bvm_pkg::ERR_PC;
                        else if (!ok1 || !ok2 || !ok3) err = bvm_pkg::ERR_REG;
                        else begin
                            reg_we = 1'b1;
                            reg_wd = (r_op == bvm_pkg::OPC_ADD) ? r_rb + rc : r_rb - rc;
                            n_pc   = r_pc + PW'(4);
                        end
                    end
                    bvm_pkg::OPC_STORE: begin
                        if (w3)        err = bvm_pkg::ERR_PC;
                        else if (!ok1) err = bvm_pkg::ERR_REG;
                        else if (32'(r_b2) >= bvm_pkg::MEM_BYTES) err = bvm_pkg::ERR_ADDR;
                        else begin
                            mem_we = 1'b1;
                            mem_fa = PW'(r_b2);
                            mem_wd = r_ra;
                            n_pc   = r_pc + PW'(3);
                        end
                    end
                    bvm_pkg::OPC_PRINT: begin
                        if (w2)        err = bvm_pkg::ERR_PC;
                        else if (!ok1) err = bvm_pkg::ERR_REG;
                        else begin
                            n_pv   = 1'b1;
                            n_pval = r_ra;
                            n_pc   = r_pc + PW'(2);
                        end
                    end
                    bvm_pkg::OPC_JZ: begin
                        if (w3)        err = bvm_pkg::ERR_PC;
                        else if (!ok1) err = bvm_pkg::ERR_REG;
                        else if (PW'(r_b2) >= r_plen) err = bvm_pkg::ERR_PC;
                        else if (r_ra == '0) n_pc = PW'(r_b2);
                        else n_pc = r_pc + PW'(3);
                    end
                    bvm_pkg::OPC_JMP: begin
                        if (w2)                       err = bvm_pkg::ERR_PC;
                        else if (PW'(r_b1) >= r_plen) err = bvm_pkg::ERR_PC;
                        else n_pc = PW'(r_b1);
                    end
                    bvm_pkg::OPC_PIX, bvm_pkg::OPC_PIXR: begin
                        if (w4) begin
                            err = bvm_pkg::ERR_PC;
                        end else if ((r_op == bvm_pkg::OPC_PIXR) && (!ok1 || !ok2 || !ok3)) begin
                            err = bvm_pkg::ERR_REG;
                        end else if (pix_in && (32'(pix_a) >= bvm_pkg::MEM_BYTES)) begin
                            err = bvm_pkg::ERR_ADDR;
                        end else begin
                            // off-screen pixel: no write, instruction still completes
                            mem_we = pix_in;
                            mem_fa = pix_a[PW-1:0];
                            mem_wd = pcol;
                            n_pc   = r_pc + PW'(4);
                        end
                    end
                    bvm_pkg::OPC_HALT: begin
                        n_stopped = 1'b1;
                    end
                    default: begin
                        err = bvm_pkg::ERR_OPC;
                    end
                endcase
                if (err != bvm_pkg::ERR_NONE) begin
                    n_stopped = 1'b1;
                    n_fault   = err;
                end
            end
            bvm_pkg::S_FIN: begin
                mem_re  = 1'b1;
                mem_fa  = PW'(r_addr);
                reg_re  = 1'b1;
                reg_a   = r_sel[RAW-1:0];
                n_state = bvm_pkg::S_DONE;
            end
            bvm_pkg::S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out.pc_now       = r_pc;
                    n_out.halted_flag  = r_stopped;
                    n_out.error_code   = r_fault;
                    n_out.reg_value    = (32'(r_sel) < bvm_pkg::REG_COUNT) ? reg_rdata : '0;
                    n_out.mem_value    = mem_rdata;
                    n_out.print_valid  = r_pv;
                    n_out.print_value  = r_pval;
                    n_out.fetched_byte = r_fetched;
                    n_out_valid        = 1'b1;
                    n_state            = bvm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bvm_pkg::S_IDLE;
            end
        endcase

        if (reg_we) begin
            n_reg_vld[reg_a] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bvm_pkg::S_CLEAR;
            r_clr_cnt   <= '0;
            r_plen      <= '0;
            r_pc        <= '0;
            r_stopped   <= 1'b0;
            r_fault     <= bvm_pkg::ERR_NONE;
            r_reg_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_plen      <= n_plen;
            r_pc        <= n_pc;
            r_stopped   <= n_stopped;
            r_fault     <= n_fault;
            r_reg_vld   <= n_reg_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_data    <= n_data;
        r_sel     <= n_sel;
        r_op      <= n_op;
        r_b1      <= n_b1;
        r_b2      <= n_b2;
        r_b3      <= n_b3;
        r_ra      <= n_ra;
        r_rb      <= n_rb;
        r_fetched <= n_fetched;
        r_pv      <= n_pv;
        r_pval    <= n_pval;
        r_out     <= n_out;
    end

    // byte memory, single port; reads past the top return zero
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_fa[MAW-1:0]] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q  <= mem[mem_fa[MAW-1:0]];
            r_mem_qz <= mem_oob;
        end
    end

    // register RAM; an entry not written since reset reads zero
    always_ff @(posedge i_clk) begin
        if (reg_we) begin
            regs[reg_a] <= reg_wd;
        end
        if (reg_re) begin
            r_reg_q  <= regs[reg_a];
            r_reg_qv <= r_reg_vld[reg_a];
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.pc_now       = r_out.pc_now;
    assign o_res.halted_flag  = r_out.halted_flag;
    assign o_res.error_code   = r_out.error_code;
    assign o_res.reg_value    = r_out.reg_value;
    assign o_res.mem_value    = r_out.mem_value;
    assign o_res.print_valid  = r_out.print_valid;
    assign o_res.print_value  = r_out.print_value;
    assign o_res.fetched_byte = r_out.fetched_byte;

endmodule
`default_nettype wire
